FILE: sv/stepper_axis_dda_with_endstops_defines.svh
// Assertion macros shared by the stepper axis modules.
`ifndef STEPPER_AXIS_DDA_WITH_ENDSTOPS_DEFINES_SVH
`define STEPPER_AXIS_DDA_WITH_ENDSTOPS_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SDDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sdda_pkg.sv
// Types, constants and helpers for the DDA stepper axis.
package sdda_pkg;

  localparam int unsigned POS_WIDTH  = 32;
  localparam int unsigned PLAY_WIDTH = 8;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CMP_W      = ((PLAY_WIDTH > CFG_W) ? PLAY_WIDTH : CFG_W) + 1;
  localparam int unsigned DIFF_W     = (POS_WIDTH > 32) ? POS_WIDTH : 32;

  typedef enum logic [2:0] {
    CMD_SET_TARGET      = 3'd0,
    CMD_START_HOMING    = 3'd1,
    CMD_DEFINE_POSITION = 3'd2,
    CMD_TICK            = 3'd3,
    CMD_HOMING_TICK     = 3'd4,
    CMD_PRESET_COUNTER  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ES_UNKNOWN   = 2'd0,
    ES_TRAVELING = 2'd1,
    ES_AT_MAX    = 2'd2,
    ES_AT_MIN    = 2'd3
  } es_e;

  localparam logic [1:0] CFG_SINGLE_SWITCH = 2'd0;
  localparam logic [1:0] CFG_PLAY_RELOAD   = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE      = 2'd2;

  localparam logic             RST_SINGLE_SWITCH = 1'b1;
  localparam logic [CFG_W-1:0] RST_PLAY_RELOAD   = 8'd20;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE      = 8'd5;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic               relative;
    logic               toward_max;
    logic [30:0]        intervals;
    logic [4:0]         step_mult;
    logic               at_maximum;
    logic               at_minimum;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         step_pulses;
    logic               dir_out;
    logic               enable_request;
    logic               still_active;
    logic [1:0]         endstop_state;
    logic signed [31:0] position_out;
  } out_item_t;

  typedef struct packed {
    logic             single_switch_mode;
    logic [CFG_W-1:0] play_reload;
    logic [CFG_W-1:0] debounce_distance;
  } es_cfg_t;

  typedef struct packed {
    logic check;
    logic homing;
    logic moving_up;
    logic at_max;
    logic at_min;
  } es_req_t;

  function automatic logic [PLAY_WIDTH-1:0] play_fit(input logic [CFG_W-1:0] v);
    return PLAY_WIDTH'(v);
  endfunction

endpackage

FILE: sv/sdda_endstop.sv
// Endstop debounce machine with its play counter.
`include "stepper_axis_dda_with_endstops_defines.svh"

module sdda_endstop import sdda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  es_cfg_t cfg_i,
  input  es_req_t req_i,
  output logic    hit_o,
  output es_e     state_o
);

  logic [PLAY_WIDTH-1:0] play_left_q, play_left_d;
  es_e                   stop_state_q, stop_state_d;
  logic                  last_dir_q, last_dir_d;

  logic                  raw_hit;
  logic                  below_thr;
  logic [PLAY_WIDTH-1:0] reload_val;
  logic signed [CMP_W-1:0] play_s, limit_s;

  always_comb begin
    play_left_d  = play_left_q;
    stop_state_d = stop_state_q;
    last_dir_d   = last_dir_q;
    raw_hit      = req_i.moving_up ? req_i.at_max : req_i.at_min;
    hit_o        = raw_hit;
    reload_val   = play_fit(cfg_i.play_reload);
    play_s       = signed'(CMP_W'(play_left_q));
    limit_s      = signed'(CMP_W'(cfg_i.play_reload)) - signed'(CMP_W'(cfg_i.debounce_distance));
    below_thr    = play_s < limit_s;
    if (cfg_i.single_switch_mode) begin
      if (raw_hit || (below_thr && stop_state_q != ES_TRAVELING)) begin
        if (stop_state_q == ES_TRAVELING || (req_i.homing && stop_state_q == ES_UNKNOWN)) begin
          play_left_d  = reload_val;
          stop_state_d = (req_i.homing ? req_i.moving_up : last_dir_q) ? ES_AT_MAX : ES_AT_MIN;
        end else if ((req_i.moving_up && stop_state_q != ES_AT_MAX) ||
                     (!req_i.moving_up && stop_state_q != ES_AT_MIN)) begin
          // Still inside the play window: swallow the switch and spend play.
          if (play_left_q != '0) begin
            play_left_d = play_left_q - PLAY_WIDTH'(1);
            hit_o       = 1'b0;
          end
        end
      end else begin
        stop_state_d = ES_TRAVELING;
        if (!req_i.homing) begin
          play_left_d = reload_val;
        end
      end
      last_dir_d = req_i.moving_up;
    end
    state_o = req_i.check ? stop_state_d : stop_state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_left_q  <= play_fit(RST_PLAY_RELOAD);
      stop_state_q <= ES_UNKNOWN;
      last_dir_q   <= 1'b0;
    end else if (req_i.check) begin
      play_left_q  <= play_left_d;
      stop_state_q <= stop_state_d;
      last_dir_q   <= last_dir_d;
    end
  end

  `SDDA_ASSERT_NEXT(a_state_never_unknown_again, stop_state_q != ES_UNKNOWN, stop_state_q != ES_UNKNOWN, "endstop state fell back to unknown")
  `SDDA_ASSERT_NEXT(a_raw_mode_holds_state, !cfg_i.single_switch_mode, $stable(stop_state_q) && $stable(play_left_q), "raw switch mode changed the debounce state")

endmodule

FILE: sv/sdda_axis.sv
// Axis datapath: command decode, DDA error counter, position and direction.
module sdda_axis import sdda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  logic      es_hit_i,
  input  es_e       es_state_i,
  output es_req_t   es_req_o,
  output out_item_t result_o
);

  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [31:0]          err_q, err_d;
  logic [31:0]          delta_q, delta_d;
  logic                 up_q, up_d;
  logic                 neg_q, neg_d;

  logic [31:0]          err_add, err_sub;
  logic [POS_WIDTH-1:0] step_amt, pos_step;
  logic signed [DIFF_W-1:0] diff;
  logic [31:0]          tgt_dist;
  logic [4:0]           pulses;
  logic                 enable, active;

  always_comb begin
    pos_d    = pos_q;
    err_d    = err_q;
    delta_d  = delta_q;
    up_d     = up_q;
    neg_d    = neg_q;
    pulses   = '0;
    enable   = 1'b0;
    active   = 1'b0;
    es_req_o = '{check: 1'b0, homing: 1'b0, moving_up: up_q,
                 at_max: item_i.at_maximum, at_min: item_i.at_minimum};

    err_add  = err_q + delta_q;
    err_sub  = err_add - {1'b0, item_i.intervals};
    step_amt = POS_WIDTH'(item_i.step_mult);
    pos_step = neg_q ? (pos_q - step_amt) : (pos_q + step_amt);
    diff     = DIFF_W'(item_i.value) - DIFF_W'(signed'(pos_q));
    tgt_dist = item_i.relative ? item_i.value : diff[31:0];

    unique case (cmd_e'(item_i.command))
      CMD_SET_TARGET: begin
        delta_d = tgt_dist;
        if (tgt_dist != '0) begin
          enable = 1'b1;
          if (tgt_dist[31]) begin
            delta_d = -tgt_dist;
            up_d    = 1'b0;
            neg_d   = 1'b1;
          end else begin
            up_d    = 1'b1;
            neg_d   = 1'b0;
          end
        end
      end
      CMD_START_HOMING: begin
        up_d    = item_i.toward_max;
        enable  = 1'b1;
        delta_d = 32'd1;
        neg_d   = !item_i.toward_max;
      end
      CMD_DEFINE_POSITION: begin
        pos_d = POS_WIDTH'(item_i.value);
      end
      CMD_TICK: begin
        if (delta_q != '0) begin
          es_req_o.check = fire_i;
          err_d = err_add;
          if (!err_add[31]) begin
            err_d = err_sub;
            pos_d = pos_step;
            if (!es_hit_i) begin
              pulses = item_i.step_mult;
            end
          end
          active = !es_hit_i;
        end
      end
      CMD_HOMING_TICK: begin
        if (delta_q != '0) begin
          active = 1'b1;
          err_d  = err_add;
          if (!err_add[31]) begin
            // The switch is only examined on ticks that would step.
            err_d           = err_sub;
            es_req_o.check  = fire_i;
            es_req_o.homing = 1'b1;
            if (es_hit_i) begin
              active = 1'b0;
            end else begin
              pulses = item_i.step_mult;
              pos_d  = pos_step;
            end
          end
        end
      end
      CMD_PRESET_COUNTER: begin
        err_d = item_i.value;
      end
      default: begin
      end
    endcase

    result_o.step_pulses    = pulses;
    result_o.dir_out        = up_d;
    result_o.enable_request = enable;
    result_o.still_active   = active;
    result_o.endstop_state  = es_state_i;
    result_o.position_out   = 32'(signed'(pos_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      err_q   <= '0;
      delta_q <= '0;
      up_q    <= 1'b0;
      neg_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      err_q   <= err_d;
      delta_q <= delta_d;
      up_q    <= up_d;
      neg_q   <= neg_d;
    end
  end

endmodule

FILE: sv/stepper_axis_dda_with_endstops.sv
// One axis of a DDA step generator with endstop debounce. The block accepts one
// command transaction per clock cycle while the input is not stalled and returns
// exactly one result transaction for it: the command is captured in an input
// register, decoded and applied in a single pass (the error counter update is the
// longest path, an add of the delta followed by a subtract of the interval count),
// and the result lands in an output register. A stalled result register holds the
// input register, and the input stalls only while both are full. Configuration
// writes are always ready and take effect on the next command; write them only
// while no command is in flight. There is no clearing pass after reset.
`include "stepper_axis_dda_with_endstops_defines.svh"

module stepper_axis_dda_with_endstops import sdda_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  es_cfg_t   cfg_q;

  logic      advance;
  logic      fire;
  es_req_t   es_req;
  logic      es_hit;
  es_e       es_state;
  out_item_t result;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  sdda_axis u_axis (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_q),
    .es_hit_i   (es_hit),
    .es_state_i (es_state),
    .es_req_o   (es_req),
    .result_o   (result)
  );

  sdda_endstop u_endstop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .req_i   (es_req),
    .hit_o   (es_hit),
    .state_o (es_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.single_switch_mode <= RST_SINGLE_SWITCH;
      cfg_q.play_reload        <= RST_PLAY_RELOAD;
      cfg_q.debounce_distance  <= RST_DEBOUNCE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SINGLE_SWITCH: cfg_q.single_switch_mode <= cfg_data_i[0];
        CFG_PLAY_RELOAD:   cfg_q.play_reload        <= cfg_data_i;
        CFG_DEBOUNCE:      cfg_q.debounce_distance  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  `SDDA_ASSERT_IMPL(a_stall_only_when_full, in_stall_o, in_valid_q && out_valid_q, "input stalled with a free stage")
  `SDDA_ASSERT_NEXT(a_stage_holds_on_stall, in_stall_o, in_valid_q && $stable(in_q), "stalled command left the input register")
  `SDDA_ASSERT_IMPL(a_pulses_imply_active, out_valid_o && out_data_o.step_pulses != 5'd0, out_data_o.still_active, "step pulses issued on an inactive result")
  `SDDA_ASSERT_IMPL(a_enable_not_on_tick, out_valid_o && out_data_o.enable_request, !out_data_o.still_active, "enable request and active tick in one result")

endmodule
